// ===== rtl/utda_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the unsigned to decimal ASCII converter.
// No dependencies; every other file depends on this package.
package utda_pkg;

    localparam int VALUE_W = 64;   // width of the input value field
    localparam int DIGIT_W = 4;    // one BCD digit per cell
    localparam int CHAR_W  = 6;    // width of the output character field

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;   // ASCII '0' in six bits

    // Operation applied by every cell in the digit chain.
    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_CLEAR,
        MODE_CONV,
        MODE_SHIFT
    } t_cell_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/utda_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the converter: input values and output characters.
// Depends on utda_pkg for field widths.
interface utda_in_if;
    logic                          valid;
    logic                          ready;
    logic [utda_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface utda_out_if;
    logic                          valid;
    logic                          ready;
    logic [utda_pkg::CHAR_W-1:0]   digit_char;
    logic                          last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== rtl/utda_digit_cell.sv =====
`timescale 1ns / 1ps
// One BCD digit cell of the conversion chain: shift-add-3 step and digit shift.
// Depends on utda_pkg for t_cell_mode and DIGIT_W.
module utda_digit_cell (
    input  logic                              i_clk,
    input  utda_pkg::t_cell_mode              i_mode,
    input  logic                              i_carry,
    input  logic [utda_pkg::DIGIT_W-1:0]      i_digit,
    output logic                              o_carry,
    output logic [utda_pkg::DIGIT_W-1:0]      o_digit
);
    import utda_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    // Add 3 before the shift so the doubled digit overflows into the next cell.
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        unique case (i_mode)
            MODE_HOLD:  n_digit = r_digit;
            MODE_CLEAR: n_digit = '0;
            MODE_CONV:  n_digit = {w_adj[DIGIT_W-2:0], i_carry};
            MODE_SHIFT: n_digit = i_digit;
            default:    n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== rtl/unsigned_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// Top level of the unsigned to decimal ASCII converter: sequencer, value shifter,
// digit cell chain and output register. Depends on utda_pkg, utda_if, utda_digit_cell.
//
//  channel     | dir | payload               | handshake
//  ------------+-----+-----------------------+-------------
//  i_value_ch  | in  | value[63:0]           | valid/ready
//  o_char_ch   | out | digit_char[5:0], last | valid/ready
//
// An item is accepted, then shifted through the digit chain by shift-add-3 (one input
// bit per cycle); then the top cell shifts digits out, dropping leading zeros and
// sending the rest, over NUM_DIGITS digit positions in all.
// The cell chain holds one value at a time; i_value_ch.ready is high only when it is idle.
// Output stalls freeze the chain once a digit is due; leading zeros still drop meanwhile.
// The last character may wait while a new value loads.
// Reset is synchronous, active low, clears the sequencer and output valid, and holds
// i_value_ch.ready low.
module unsigned_to_decimal_ascii_core #(
    parameter int VALUE_BITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utda_in_if.sink       i_value_ch,
    utda_out_if.source    o_char_ch
);
    import utda_pkg::*;

    // ceil(VALUE_BITS * log10(2)) digits hold the largest value
    localparam int NUM_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    t_state                 r_state;
    t_state                 n_state;
    t_cell_mode             w_mode;
    logic                   w_in_ready;

    logic [VALUE_BITS-1:0]  r_value;
    logic [BIT_CNT_W-1:0]   r_bit_cnt;
    logic [DIG_CNT_W-1:0]   r_dig_cnt;
    logic                   r_started;

    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_out_last;

    logic                   w_in_xfer;
    logic                   w_out_free;
    logic                   w_skip;
    logic                   w_emit;
    logic                   w_shift_out;
    logic                   w_final;
    logic [DIGIT_W-1:0]     w_top;

    logic [DIGIT_W-1:0]     w_digit [NUM_DIGITS];
    logic                   w_carry [NUM_DIGITS+1];

    assign w_in_xfer  = i_value_ch.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_char_ch.ready;
    assign w_top      = w_digit[NUM_DIGITS-1];
    assign w_final    = (r_dig_cnt == DIG_CNT_W'(1));
    // Drop leading zeros, but never the final digit.
    assign w_skip      = !r_started && (w_top == '0) && !w_final;
    assign w_emit      = (r_state == ST_EMIT) && !w_skip && w_out_free;
    assign w_shift_out = (r_state == ST_EMIT) && (w_skip || w_out_free);

    // Digit chain: cell 0 is least significant, the top cell feeds the output.
    assign w_carry[0] = r_value[VALUE_BITS-1];

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        logic [DIGIT_W-1:0] w_digit_in;

        if (g == 0) begin : g_low
            assign w_digit_in = '0;
        end else begin : g_mid
            assign w_digit_in = w_digit[g-1];
        end

        utda_digit_cell u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode),
            .i_carry (w_carry[g]),
            .i_digit (w_digit_in),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) n_state = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (r_bit_cnt == '0) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_emit && w_final) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_mode     = MODE_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                // Take no transfer while reset is held.
                w_in_ready = i_rst_n;
                w_mode     = i_value_ch.valid ? MODE_CLEAR : MODE_HOLD;
            end
            ST_CONVERT: begin
                w_mode = MODE_CONV;
            end
            ST_EMIT: begin
                w_mode = w_shift_out ? MODE_SHIFT : MODE_HOLD;
            end
            default: begin
                w_in_ready = 1'b0;
                w_mode     = MODE_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Value shifter and counters
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_value   <= i_value_ch.value[VALUE_BITS-1:0];
            r_bit_cnt <= BIT_CNT_W'(VALUE_BITS - 1);
        end else if (r_state == ST_CONVERT) begin
            r_value   <= {r_value[VALUE_BITS-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt - BIT_CNT_W'(1);
        end

        if (r_state == ST_CONVERT) begin
            r_dig_cnt <= DIG_CNT_W'(NUM_DIGITS);
            r_started <= 1'b0;
        end else if (w_shift_out) begin
            r_dig_cnt <= r_dig_cnt - DIG_CNT_W'(1);
            if (w_emit) r_started <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_char_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, w_top};
            r_out_last <= w_final;
        end
    end

    assign i_value_ch.ready     = w_in_ready;
    assign o_char_ch.valid      = r_out_valid;
    assign o_char_ch.digit_char = r_out_char;
    assign o_char_ch.last       = r_out_last;

endmodule

// ===== rtl/utda_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the converter's output channel, and the bind to the top level.
// Depends on utda_pkg for CHAR_W and CHAR_ZERO.
module utda_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [utda_pkg::CHAR_W-1:0]   i_out_char,
    input logic                          i_out_last
);
    import utda_pkg::*;

    logic r_first;
    logic w_out_xfer;

    assign w_out_xfer = i_out_valid && i_out_ready;

    // Track whether the next character opens a new number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (w_out_xfer) begin
            r_first <= i_out_last;
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid not cleared by reset");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transfer");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_char) && $stable(i_out_last))
        else $error("stalled output payload changed");

    a_char_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char >= CHAR_ZERO) && (i_out_char <= CHAR_ZERO + 6'd9))
        else $error("output character is not a decimal digit");

    a_no_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_first && (i_out_char == CHAR_ZERO) |-> i_out_last)
        else $error("number opens with a leading zero");

endmodule

bind unsigned_to_decimal_ascii_core utda_checker u_utda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_char_ch.valid),
    .i_out_ready (o_char_ch.ready),
    .i_out_char  (o_char_ch.digit_char),
    .i_out_last  (o_char_ch.last)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for unsigned_to_decimal_ascii_core: decimal text of 64-bit values.
// Depends on utda_pkg, utda_if and the core; a local predictor checks every character.
module testbench;
    import utda_pkg::*;

    localparam int VALUE_BITS   = 64;
    localparam int RANDOM_ITEMS = 205;
    localparam int LONG_HOLD    = 500;
    localparam int DRAIN_CYCLES = 2 * VALUE_BITS + 40;
    localparam logic [VALUE_W-1:0] RADIX      = 64'd10;
    localparam logic [VALUE_W-1:0] VALUE_MASK =
        (VALUE_BITS == 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_char_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    utda_in_if  value_ch ();
    utda_out_if char_ch ();

    unsigned_to_decimal_ascii_core #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value_ch (value_ch),
        .o_char_ch  (char_ch)
    );

    // Directed rows: an empty string means the predictor supplies the text.
    localparam int DIR_ROWS = 17;
    logic [VALUE_W-1:0] dir_value [DIR_ROWS] = '{
        64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
        64'd12345678901234567890, 64'd9999999999999999999, 64'd10000000000000000000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000, 64'd1000000007
    };
    string dir_text [DIR_ROWS] = '{
        "0", "", "9", "", "", "",
        "", "9999999999999999999", "",
        "18446744073709551615", "", "",
        "", "",
        "", "", ""
    };

    t_char_result expected_chars [$];
    string        offered_text;
    int unsigned  fail_count    = 0;
    int unsigned  hold_requests = 0;
    int unsigned  holds_done    = 0;
    bit           no_idle       = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] r;
        logic [VALUE_W-1:0] p;
        int unsigned        pick;
        int unsigned        k;
        r    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 25) return r;
        if (pick < 60) return r >> $urandom_range(0, 63);
        if (pick < 75) return 64'($urandom_range(0, 999));
        // Neighbors of a power of ten: digit count changes right there.
        p = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) p = p * RADIX;
        return p + 64'($urandom_range(0, 2)) - 64'd1;
    endfunction

    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] n;
        logic [CHAR_W-1:0]  digits [$];
        n = raw & VALUE_MASK;
        do begin
            digits.push_front(CHAR_ZERO + CHAR_W'(n % RADIX));
            n = n / RADIX;
        end while (n != 0);
        foreach (digits[i])
            expected_chars.push_back('{digits[i], i == digits.size() - 1});
    endfunction

    function automatic void queue_typed_text(input string text);
        for (int i = 0; i < text.len(); i++)
            expected_chars.push_back('{CHAR_W'(text[i]), i == text.len() - 1});
    endfunction

    // Predict on input transfers, check on output transfers.
    always @(posedge i_clk) begin
        t_char_result want;
        if (i_rst_n && value_ch.valid && value_ch.ready) begin
            if (offered_text.len() == 0)
                queue_decimal_text(value_ch.value);
            else
                queue_typed_text(offered_text);
        end
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character: digit_char %0d last %0b",
                       char_ch.digit_char, char_ch.last);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (char_ch.digit_char !== want.digit_char) begin
                    $error("digit_char mismatch: expected %0d, actual %0d",
                           want.digit_char, char_ch.digit_char);
                    fail_count++;
                end
                if (char_ch.last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b",
                           want.last, char_ch.last);
                    fail_count++;
                end
            end
        end
    end

    task automatic offer_value(input logic [VALUE_W-1:0] v, input string text);
        int unsigned gap;
        gap = no_idle ? 0 : idle_len();
        if (gap != 0) begin
            value_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        offered_text   <= text;
        do @(posedge i_clk); while (!value_ch.ready);
    endtask

    // Character sink: random stalls, plus one long hold-off on request.
    initial begin
        int unsigned stall;
        char_ch.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                char_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = no_idle ? 0 : idle_len();
                if (stall != 0) begin
                    char_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                char_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Value source and end of run.
    initial begin
        value_ch.valid <= 1'b0;
        value_ch.value <= '0;
        offered_text   <= "";
        wait (i_rst_n);
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++)
            offer_value(dir_value[k], dir_text[k]);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // Stall the sink for a long stretch while values keep coming.
            if (k == 40)
                hold_requests++;
            // Hold the source until every character has drained.
            if (k == 100) begin
                value_ch.valid <= 1'b0;
                do @(posedge i_clk); while (expected_chars.size() != 0);
            end
            no_idle = (k >= 140 && k < 170);
            offer_value(random_value(), "");
        end

        value_ch.valid <= 1'b0;
        no_idle = 1'b1;
        do @(posedge i_clk); while (expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
